>>> rtl/prqs_pkg.sv
// ----------------------------------------------------------------------------
// prqs_pkg
// shared widths, command and status codes and item types of the ready-queue
// scheduler
// ----------------------------------------------------------------------------
package prqs_pkg;

    localparam int TID_W          = 6;
    localparam int PRIO_W         = 5;
    localparam int LEVELS_W       = 32;
    localparam int CMD_W          = 2;
    localparam int STATUS_W       = 2;

    localparam int NUM_LEVELS_DEF = 32;
    localparam int NUM_TASKS_DEF  = 64;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT   = 2'd0,
        CMD_REMOVE   = 2'd1,
        CMD_SCHEDULE = 2'd2
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_DONE    = 2'd0,
        STATUS_INVALID = 2'd1,
        STATUS_EMPTY   = 2'd2
    } status_t;

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [TID_W-1:0]  task_id;
        logic [PRIO_W-1:0] priority_req;
        logic [TID_W-1:0]  current_task;
    } cmd_item_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [TID_W-1:0]    next_task;
        logic                switch_pending;
        logic [LEVELS_W-1:0] ready_levels;
    } res_item_t;

endpackage

>>> rtl/prqs_stream_if.sv
// ----------------------------------------------------------------------------
// prqs_stream_if
// valid/ready channel carrying one item per handshake
// ----------------------------------------------------------------------------
interface prqs_stream_if #(
    parameter type payload_t = logic
);

    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);

endinterface

>>> rtl/priority_ready_queue_scheduler_unit.sv
// ----------------------------------------------------------------------------
// priority_ready_queue_scheduler_unit
// per-level task fifos as linked lists with a bitmap of non-empty levels
// a command is registered into the execute stage, then its result into the result register
// throughput: one command per cycle, held only by a stalled result register
// the link and level stores are read at accept and forwarded around the write
// reset (async, active low): empty bitmap, no task ready, chosen task 0
// ----------------------------------------------------------------------------
module priority_ready_queue_scheduler_unit #(
    parameter int NUM_LEVELS = prqs_pkg::NUM_LEVELS_DEF,
    parameter int NUM_TASKS  = prqs_pkg::NUM_TASKS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    prqs_stream_if.sink   cmd,
    prqs_stream_if.source res
);

    import prqs_pkg::*;

    localparam int LVL_IDX_W  = $clog2(NUM_LEVELS);
    localparam int TASK_IDX_W = $clog2(NUM_TASKS);
    localparam int TASK_CMP_W = ((TID_W > TASK_IDX_W) ? TID_W : TASK_IDX_W) + 1;
    localparam int PRIO_CMP_W = PRIO_W + 1;

    // task id to store address
    function automatic logic [TASK_IDX_W-1:0] to_idx(input logic [TID_W-1:0] id);
        logic [TASK_CMP_W-1:0] wide;
        wide = TASK_CMP_W'(id);
        return wide[TASK_IDX_W-1:0];
    endfunction

    // ------------------------------------------------------------------------
    // handshake and stage control
    // ------------------------------------------------------------------------
    logic      e_valid_reg;
    cmd_item_t e_item_reg;
    logic      out_valid_reg;
    res_item_t out_item_reg;
    logic      e_fire;
    logic      cmd_accept;

    // execute stage retires when the result register is free or being drained
    assign e_fire     = e_valid_reg && (!out_valid_reg || res.ready);
    assign cmd.ready  = !e_valid_reg || e_fire;
    assign cmd_accept = cmd.valid && cmd.ready;

    assign res.valid   = out_valid_reg;
    assign res.payload = out_item_reg;

    // ------------------------------------------------------------------------
    // scheduler state
    // ------------------------------------------------------------------------
    logic [NUM_LEVELS-1:0] bitmap_reg, bitmap_next;
    logic [NUM_TASKS-1:0]  ready_reg, ready_next;
    logic [TID_W-1:0]      chosen_reg, chosen_next;
    logic [TID_W-1:0]      head_reg [NUM_LEVELS];
    logic [TID_W-1:0]      tail_reg [NUM_LEVELS];

    // head and tail write ports
    logic                  head_we;
    logic [LVL_IDX_W-1:0]  head_waddr;
    logic [TID_W-1:0]      head_wdata;
    logic                  tail_we;
    logic [LVL_IDX_W-1:0]  tail_waddr;
    logic [TID_W-1:0]      tail_wdata;

    // link and level store ports
    logic                  nxt_we_c, nxt_we;
    logic [TASK_IDX_W-1:0] nxt_waddr;
    logic [TID_W-1:0]      nxt_wdata, nxt_rdata;
    logic                  prv_we_c, prv_we;
    logic [TASK_IDX_W-1:0] prv_waddr;
    logic [TID_W-1:0]      prv_wdata, prv_rdata;
    logic                  lvl_we_c, lvl_we;
    logic [TASK_IDX_W-1:0] lvl_waddr;
    logic [LVL_IDX_W-1:0]  lvl_wdata, lvl_rdata;
    logic [TASK_IDX_W-1:0] raddr_in;

    // bypass of a write landing on the address read in the same cycle
    logic                  fwd_nxt_reg, fwd_prv_reg, fwd_lvl_reg;
    logic [TID_W-1:0]      fwd_nxt_data_reg, fwd_prv_data_reg;
    logic [LVL_IDX_W-1:0]  fwd_lvl_data_reg;

    assign raddr_in = to_idx(cmd.payload.task_id);
    assign nxt_we   = e_fire && nxt_we_c;
    assign prv_we   = e_fire && prv_we_c;
    assign lvl_we   = e_fire && lvl_we_c;

    prqs_ram #(.DEPTH(NUM_TASKS), .DATA_W(TID_W)) u_link_next (
        .clk   (clk),
        .we    (nxt_we),
        .waddr (nxt_waddr),
        .wdata (nxt_wdata),
        .re    (cmd_accept),
        .raddr (raddr_in),
        .rdata (nxt_rdata)
    );

    prqs_ram #(.DEPTH(NUM_TASKS), .DATA_W(TID_W)) u_link_prev (
        .clk   (clk),
        .we    (prv_we),
        .waddr (prv_waddr),
        .wdata (prv_wdata),
        .re    (cmd_accept),
        .raddr (raddr_in),
        .rdata (prv_rdata)
    );

    prqs_ram #(.DEPTH(NUM_TASKS), .DATA_W(LVL_IDX_W)) u_task_level (
        .clk   (clk),
        .we    (lvl_we),
        .waddr (lvl_waddr),
        .wdata (lvl_wdata),
        .re    (cmd_accept),
        .raddr (raddr_in),
        .rdata (lvl_rdata)
    );

    // ------------------------------------------------------------------------
    // operand selection in the execute stage
    // ------------------------------------------------------------------------
    logic [TID_W-1:0]      link_nxt_t, link_prv_t;
    logic [LVL_IDX_W-1:0]  lvl_t;
    logic [LVL_IDX_W-1:0]  p_idx;
    logic [TASK_IDX_W-1:0] t_idx;
    logic                  t_ok, p_ok;
    logic [LVL_IDX_W-1:0]  sched_lvl;
    logic [LVL_IDX_W-1:0]  head_raddr, tail_raddr;
    logic [TID_W-1:0]      head_rd, tail_rd;

    assign link_nxt_t = fwd_nxt_reg ? fwd_nxt_data_reg : nxt_rdata;
    assign link_prv_t = fwd_prv_reg ? fwd_prv_data_reg : prv_rdata;
    assign lvl_t      = fwd_lvl_reg ? fwd_lvl_data_reg : lvl_rdata;

    assign t_idx = to_idx(e_item_reg.task_id);
    assign p_idx = e_item_reg.priority_req[LVL_IDX_W-1:0];
    assign t_ok  = TASK_CMP_W'(e_item_reg.task_id) < TASK_CMP_W'(NUM_TASKS);
    assign p_ok  = PRIO_CMP_W'(e_item_reg.priority_req) < PRIO_CMP_W'(NUM_LEVELS);

    // lowest-numbered non-empty level
    always_comb
    begin
        sched_lvl = '0;
        for (int i = NUM_LEVELS - 1; i >= 0; i--)
        begin
            if (bitmap_reg[i])
            begin
                sched_lvl = LVL_IDX_W'(i);
            end
        end
    end

    // one read address per list end: schedule and remove share the head,
    // insert and remove share the tail
    assign head_raddr = (e_item_reg.command == CMD_SCHEDULE) ? sched_lvl : lvl_t;
    assign tail_raddr = (e_item_reg.command == CMD_INSERT) ? p_idx : lvl_t;
    assign head_rd    = head_reg[head_raddr];
    assign tail_rd    = tail_reg[tail_raddr];

    // ------------------------------------------------------------------------
    // command execution
    // ------------------------------------------------------------------------
    status_t status_c;
    logic    sw_c;

    always_comb
    begin
        bitmap_next = bitmap_reg;
        ready_next  = ready_reg;
        chosen_next = chosen_reg;
        status_c    = STATUS_DONE;
        sw_c        = 1'b0;
        head_we     = 1'b0;
        head_waddr  = head_raddr;
        head_wdata  = e_item_reg.task_id;
        tail_we     = 1'b0;
        tail_waddr  = tail_raddr;
        tail_wdata  = e_item_reg.task_id;
        nxt_we_c    = 1'b0;
        nxt_waddr   = to_idx(tail_rd);
        nxt_wdata   = e_item_reg.task_id;
        prv_we_c    = 1'b0;
        prv_waddr   = t_idx;
        prv_wdata   = tail_rd;
        lvl_we_c    = 1'b0;
        lvl_waddr   = t_idx;
        lvl_wdata   = p_idx;

        case (e_item_reg.command)
            CMD_INSERT:
            begin
                if (t_ok && p_ok && !ready_reg[t_idx])
                begin
                    if (!bitmap_reg[p_idx])
                    begin
                        // first task on an empty level
                        head_we             = 1'b1;
                        head_waddr          = p_idx;
                        tail_we             = 1'b1;
                        bitmap_next[p_idx]  = 1'b1;
                    end
                    else
                    begin
                        // append behind the current tail
                        nxt_we_c = 1'b1;
                        prv_we_c = 1'b1;
                        tail_we  = 1'b1;
                    end
                    lvl_we_c          = 1'b1;
                    ready_next[t_idx] = 1'b1;
                end
                else
                begin
                    status_c = STATUS_INVALID;
                end
            end

            CMD_REMOVE:
            begin
                if (t_ok && ready_reg[t_idx])
                begin
                    if (e_item_reg.task_id == head_rd && e_item_reg.task_id == tail_rd)
                    begin
                        // only task on its level
                        bitmap_next[lvl_t] = 1'b0;
                    end
                    else if (e_item_reg.task_id == head_rd)
                    begin
                        head_we    = 1'b1;
                        head_wdata = link_nxt_t;
                    end
                    else if (e_item_reg.task_id == tail_rd)
                    begin
                        tail_we    = 1'b1;
                        tail_wdata = link_prv_t;
                    end
                    else
                    begin
                        // splice neighbors together
                        nxt_we_c  = 1'b1;
                        nxt_waddr = to_idx(link_prv_t);
                        nxt_wdata = link_nxt_t;
                        prv_we_c  = 1'b1;
                        prv_waddr = to_idx(link_nxt_t);
                        prv_wdata = link_prv_t;
                    end
                    ready_next[t_idx] = 1'b0;
                end
                else
                begin
                    status_c = STATUS_INVALID;
                end
            end

            CMD_SCHEDULE:
            begin
                if (bitmap_reg == '0)
                begin
                    status_c = STATUS_EMPTY;
                end
                else if (head_rd != e_item_reg.current_task)
                begin
                    chosen_next = head_rd;
                    sw_c        = 1'b1;
                end
            end

            default:
            begin
                status_c = STATUS_INVALID;
            end
        endcase
    end

    // ------------------------------------------------------------------------
    // registers
    // ------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            bitmap_reg    <= '0;
            ready_reg     <= '0;
            chosen_reg    <= '0;
            fwd_nxt_reg   <= 1'b0;
            fwd_prv_reg   <= 1'b0;
            fwd_lvl_reg   <= 1'b0;
        end
        else
        begin
            if (cmd_accept)
            begin
                e_valid_reg <= 1'b1;
                fwd_nxt_reg <= nxt_we && (nxt_waddr == raddr_in);
                fwd_prv_reg <= prv_we && (prv_waddr == raddr_in);
                fwd_lvl_reg <= lvl_we && (lvl_waddr == raddr_in);
            end
            else if (e_fire)
            begin
                e_valid_reg <= 1'b0;
            end

            if (e_fire)
            begin
                out_valid_reg <= 1'b1;
                bitmap_reg    <= bitmap_next;
                ready_reg     <= ready_next;
                chosen_reg    <= chosen_next;
            end
            else if (res.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_accept)
        begin
            e_item_reg       <= cmd.payload;
            fwd_nxt_data_reg <= nxt_wdata;
            fwd_prv_data_reg <= prv_wdata;
            fwd_lvl_data_reg <= lvl_wdata;
        end
        if (e_fire)
        begin
            out_item_reg.status         <= status_c;
            out_item_reg.next_task      <= chosen_next;
            out_item_reg.switch_pending <= sw_c;
            out_item_reg.ready_levels   <= LEVELS_W'(bitmap_next);
        end
        if (e_fire && head_we)
        begin
            head_reg[head_waddr] <= head_wdata;
        end
        if (e_fire && tail_we)
        begin
            tail_reg[tail_waddr] <= tail_wdata;
        end
    end

endmodule

>>> rtl/prqs_ram.sv
// ----------------------------------------------------------------------------
// prqs_ram
// one write port, one registered read port
// ----------------------------------------------------------------------------
module prqs_ram #(
    parameter int DEPTH  = 64,
    parameter int DATA_W = 6
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [DATA_W-1:0]        wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [DATA_W-1:0]        rdata
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // read before write on a shared address
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> rtl/prqs_checker.sv
// ----------------------------------------------------------------------------
// prqs_checker
// port-level checks on the scheduler result channel
// ----------------------------------------------------------------------------
module prqs_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                res_valid,
    input logic                res_ready,
    input prqs_pkg::res_item_t res_payload
);

    import prqs_pkg::*;

    // stalled result holds
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_payload))
        else $error("result changed while stalled");

    // a switch request only comes from a successful schedule
    a_switch_done: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_payload.switch_pending |->
            res_payload.status == STATUS_DONE && res_payload.ready_levels != '0)
        else $error("switch request without ready task");

    // no ready task means an empty bitmap and no switch
    a_empty_levels: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_payload.status == STATUS_EMPTY |->
            res_payload.ready_levels == '0 && !res_payload.switch_pending)
        else $error("empty schedule with ready levels");

    // rejected commands never request a switch
    a_invalid_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_payload.status == STATUS_INVALID |->
            !res_payload.switch_pending)
        else $error("rejected command raised switch");

endmodule

bind priority_ready_queue_scheduler_unit prqs_checker u_prqs_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .res_valid   (res.valid),
    .res_ready   (res.ready),
    .res_payload (res.payload)
);

>>> tb/sv/prqs_sched_checker.sv
// ----------------------------------------------------------------------------
// prqs_sched_checker
// watches the command and result channels of the ready-queue scheduler, keeps
// its own copy of the level queues and compares every result in order
// ----------------------------------------------------------------------------
module prqs_sched_checker (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    input  logic                cmd_ready,
    input  prqs_pkg::cmd_item_t cmd_item,
    input  logic                res_valid,
    input  logic                res_ready,
    input  prqs_pkg::res_item_t res_item,
    output int                  mismatch_count,
    output int                  outstanding
);

    import prqs_pkg::*;

    localparam int LEVEL_COUNT = NUM_LEVELS_DEF;
    localparam int TASK_COUNT  = NUM_TASKS_DEF;

    // shadow of the scheduler state
    logic [LEVELS_W-1:0] level_map;
    logic [TID_W-1:0]    head_of   [LEVEL_COUNT];
    logic [TID_W-1:0]    tail_of   [LEVEL_COUNT];
    logic [TID_W-1:0]    next_link [TASK_COUNT];
    logic [TID_W-1:0]    prev_link [TASK_COUNT];
    logic [PRIO_W-1:0]   level_of  [TASK_COUNT];
    logic                queued    [TASK_COUNT];
    logic [TID_W-1:0]    chosen;

    res_item_t sched_outcomes[$];
    int        error_total  = 0;
    int        result_index = 0;

    assign mismatch_count = error_total;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("[%0t] result %0d: %s got 0x%0h, expected 0x%0h",
                 $time, result_index, what, got, want);
        error_total++;
    endtask

    function automatic res_item_t run_queue_command(input cmd_item_t c);
        res_item_t         r;
        logic [PRIO_W-1:0] lvl;
        logic [TID_W-1:0]  t;
        logic [TID_W-1:0]  h;
        logic [TID_W-1:0]  tl;
        logic [TID_W-1:0]  p;
        logic [TID_W-1:0]  n;
        r.status         = STATUS_DONE;
        r.switch_pending = 1'b0;
        t                = c.task_id;
        case (c.command)
            CMD_INSERT:
            begin
                lvl = c.priority_req;
                if (int'(t) >= TASK_COUNT || int'(lvl) >= LEVEL_COUNT || queued[t])
                begin
                    r.status = STATUS_INVALID;
                end
                else
                begin
                    if (!level_map[lvl])
                    begin
                        head_of[lvl]   = t;
                        tail_of[lvl]   = t;
                        level_map[lvl] = 1'b1;
                    end
                    else
                    begin
                        tl            = tail_of[lvl];
                        next_link[tl] = t;
                        prev_link[t]  = tl;
                        tail_of[lvl]  = t;
                    end
                    level_of[t] = lvl;
                    queued[t]   = 1'b1;
                end
            end
            CMD_REMOVE:
            begin
                if (int'(t) >= TASK_COUNT || !queued[t])
                begin
                    r.status = STATUS_INVALID;
                end
                else
                begin
                    lvl = level_of[t];
                    h   = head_of[lvl];
                    tl  = tail_of[lvl];
                    if (t == h && t == tl)
                    begin
                        level_map[lvl] = 1'b0;
                    end
                    else if (t == h)
                    begin
                        head_of[lvl] = next_link[t];
                    end
                    else if (t == tl)
                    begin
                        tail_of[lvl] = prev_link[t];
                    end
                    else
                    begin
                        p            = prev_link[t];
                        n            = next_link[t];
                        next_link[p] = n;
                        prev_link[n] = p;
                    end
                    queued[t] = 1'b0;
                end
            end
            CMD_SCHEDULE:
            begin
                if (level_map == '0)
                begin
                    r.status = STATUS_EMPTY;
                end
                else
                begin
                    lvl = '0;
                    for (int i = LEVELS_W - 1; i >= 0; i--)
                    begin
                        if (level_map[i])
                        begin
                            lvl = i[PRIO_W-1:0];
                        end
                    end
                    h = head_of[lvl];
                    if (h != c.current_task)
                    begin
                        chosen           = h;
                        r.switch_pending = 1'b1;
                    end
                end
            end
            default:
            begin
                r.status = STATUS_INVALID;
            end
        endcase
        r.next_task    = chosen;
        r.ready_levels = level_map;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        res_item_t want;
        if (!rst_n)
        begin
            level_map = '0;
            chosen    = '0;
            for (int i = 0; i < TASK_COUNT; i++)
            begin
                queued[i] = 1'b0;
            end
            sched_outcomes.delete();
            outstanding <= 0;
        end
        else
        begin
            if (cmd_valid && cmd_ready)
            begin
                sched_outcomes.push_back(run_queue_command(cmd_item));
            end
            if (res_valid && res_ready)
            begin
                if (sched_outcomes.size() == 0)
                begin
                    report_mismatch("result with nothing outstanding, levels",
                                    res_item.ready_levels, '0);
                end
                else
                begin
                    want = sched_outcomes.pop_front();
                    if (res_item.status !== want.status)
                    begin
                        report_mismatch("status", res_item.status, want.status);
                    end
                    if (res_item.next_task !== want.next_task)
                    begin
                        report_mismatch("next_task", res_item.next_task, want.next_task);
                    end
                    if (res_item.switch_pending !== want.switch_pending)
                    begin
                        report_mismatch("switch_pending", res_item.switch_pending,
                                        want.switch_pending);
                    end
                    if (res_item.ready_levels !== want.ready_levels)
                    begin
                        report_mismatch("ready_levels", res_item.ready_levels,
                                        want.ready_levels);
                    end
                end
                result_index++;
            end
            outstanding <= sched_outcomes.size();
        end
    end

endmodule

>>> tb/sv/priority_ready_queue_scheduler_unit_tb.sv
// ----------------------------------------------------------------------------
// priority_ready_queue_scheduler_unit_tb
// drives insert, remove and schedule commands into the ready-queue scheduler
// with random gaps and result stalls; the checker beside the block predicts
// and compares every result, this module only makes stimulus and decides
// ----------------------------------------------------------------------------
module priority_ready_queue_scheduler_unit_tb;

    import prqs_pkg::*;

    // command code the block does not define, must come back as invalid
    localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;

    localparam int RANDOM_ITEMS = 1700;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int DRAIN_CYCLES = 8;
    localparam int TASK_COUNT   = NUM_TASKS_DEF;

    logic clk = 1'b0;
    logic rst_n;

    prqs_stream_if #(.payload_t(cmd_item_t)) cmd_ch ();
    prqs_stream_if #(.payload_t(res_item_t)) res_ch ();

    int               mismatch_count;
    int               outstanding;
    int               cycle_count = 0;
    int               hold_left   = 0;
    bit               no_stall    = 1'b1;
    bit               is_queued [TASK_COUNT];
    logic [TID_W-1:0] seen_next   = '0;

    // clock: 12 time units per period
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    priority_ready_queue_scheduler_unit uut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .res   (res_ch)
    );

    prqs_sched_checker sched_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd_valid      (cmd_ch.valid),
        .cmd_ready      (cmd_ch.ready),
        .cmd_item       (cmd_ch.payload),
        .res_valid      (res_ch.valid),
        .res_ready      (res_ch.ready),
        .res_item       (res_ch.payload),
        .mismatch_count (mismatch_count),
        .outstanding    (outstanding)
    );

    // gap length: mostly none or short, now and then a long one
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
        begin
            return 0;
        end
        else if (roll < 85)
        begin
            return $urandom_range(1, 3);
        end
        else if (roll < 97)
        begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    // random task that is queued (want_queued) or free; caller makes sure one exists
    function automatic logic [TID_W-1:0] pick_task(input bit want_queued);
        int start;
        int idx;
        start = $urandom_range(0, TASK_COUNT - 1);
        for (int i = 0; i < TASK_COUNT; i++)
        begin
            idx = (start + i) % TASK_COUNT;
            if (is_queued[idx] == want_queued)
            begin
                return idx[TID_W-1:0];
            end
        end
        return start[TID_W-1:0];
    endfunction

    function automatic int queued_count();
        int total;
        total = 0;
        for (int i = 0; i < TASK_COUNT; i++)
        begin
            total += is_queued[i];
        end
        return total;
    endfunction

    // result side: random stall stretches, always ready while no_stall is set
    always @(posedge clk)
    begin
        if (no_stall)
        begin
            res_ch.ready <= 1'b1;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
        end
        else
        begin
            res_ch.ready <= ($urandom_range(0, 2) != 0);
            hold_left    <= pick_gap();
        end
    end

    // last chosen task seen on the result channel, used as a likely running task
    always @(posedge clk)
    begin
        if (res_ch.valid && res_ch.ready)
        begin
            seen_next <= res_ch.payload.next_task;
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // one item on the command channel; valid stays high into the next item
    // when there is no gap, so it is never lowered and raised in one step
    task automatic issue(input logic [CMD_W-1:0] op, input logic [TID_W-1:0] tid,
                         input logic [PRIO_W-1:0] prio, input logic [TID_W-1:0] cur);
        cmd_item_t item;
        int        gap;
        item.command      = op;
        item.task_id      = tid;
        item.priority_req = prio;
        item.current_task = cur;
        gap = no_stall ? 0 : pick_gap();
        if (gap > 0)
        begin
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_ch.valid   <= 1'b1;
        cmd_ch.payload <= item;
        @(posedge clk);
        while (!cmd_ch.ready)
        begin
            @(posedge clk);
        end
        // stimulus bookkeeping only: which ids are free to insert or remove
        if (op == CMD_INSERT)
        begin
            is_queued[tid] = 1'b1;
        end
        else if (op == CMD_REMOVE)
        begin
            is_queued[tid] = 1'b0;
        end
    endtask

    initial
    begin
        logic [PRIO_W-1:0] hot_levels [4];
        logic [PRIO_W-1:0] prio;
        logic [TID_W-1:0]  cur;
        int                roll;
        int                pick;
        int                population;

        rst_n          = 1'b0;
        cmd_ch.valid   = 1'b0;
        cmd_ch.payload = '0;
        res_ch.ready   = 1'b0;
        for (int i = 0; i < TASK_COUNT; i++)
        begin
            is_queued[i] = 1'b0;
        end
        for (int i = 0; i < 4; i++)
        begin
            hot_levels[i] = 5'($urandom_range(0, 31));
        end
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part, back to back so every forwarding path is hit
        no_stall = 1'b1;
        issue(CMD_SCHEDULE, 6'd0, 5'd0, 6'd63);    // nothing ready
        issue(CMD_REMOVE, 6'd0, 5'd31, 6'd0);      // remove of a free task
        issue(CMD_SPARE, 6'd63, 5'd31, 6'd63);     // undefined command
        issue(CMD_INSERT, 6'd0, 5'd31, 6'd0);      // level 31, lowest priority
        issue(CMD_INSERT, 6'd63, 5'd0, 6'd0);      // level 0, highest priority
        issue(CMD_INSERT, 6'd5, 5'd0, 6'd0);
        issue(CMD_INSERT, 6'd7, 5'd0, 6'd0);       // three deep on level 0
        issue(CMD_INSERT, 6'd63, 5'd5, 6'd0);      // insert of a ready task
        issue(CMD_SCHEDULE, 6'd0, 5'd0, 6'd0);     // head differs, switch
        issue(CMD_SCHEDULE, 6'd0, 5'd0, 6'd63);    // head is running, no switch
        issue(CMD_REMOVE, 6'd5, 5'd0, 6'd0);       // unlink from the middle
        issue(CMD_REMOVE, 6'd63, 5'd0, 6'd0);      // unlink the head
        issue(CMD_SCHEDULE, 6'd0, 5'd0, 6'd0);
        issue(CMD_INSERT, 6'd5, 5'd0, 6'd0);
        issue(CMD_REMOVE, 6'd5, 5'd0, 6'd0);       // unlink the tail
        issue(CMD_REMOVE, 6'd7, 5'd0, 6'd0);       // last one, level bit drops
        issue(CMD_SCHEDULE, 6'd0, 5'd0, 6'd63);    // falls through to level 31
        issue(CMD_REMOVE, 6'd0, 5'd0, 6'd0);
        issue(CMD_SCHEDULE, 6'd21, 5'd10, 6'd42);  // empty again, chosen task kept
        issue(CMD_INSERT, 6'd42, 5'd16, 6'd21);
        issue(CMD_INSERT, 6'd21, 5'd15, 6'd42);
        issue(CMD_SCHEDULE, 6'd0, 5'd0, 6'd42);
        issue(CMD_REMOVE, 6'd21, 5'd0, 6'd0);
        issue(CMD_SCHEDULE, 6'd0, 5'd0, 6'd42);

        // random part: mostly legal inserts and removes over a few busy levels
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % 150 == 0)
            begin
                no_stall = ($urandom_range(0, 3) == 0);
                for (int i = 0; i < 4; i++)
                begin
                    hot_levels[i] = 5'($urandom_range(0, 31));
                end
            end
            population = queued_count();
            roll       = $urandom_range(0, 99);
            if (roll < 40 && population >= 48)
            begin
                roll = 50;
            end
            if (roll < 40 && population == TASK_COUNT)
            begin
                roll = 50;
            end
            if (roll >= 40 && roll < 65 && population == 0)
            begin
                roll = 10;
            end
            prio = ($urandom_range(0, 2) != 0) ? hot_levels[$urandom_range(0, 3)]
                                                : 5'($urandom_range(0, 31));
            if (roll < 40)
            begin
                issue(CMD_INSERT, pick_task(1'b0), prio, 6'($urandom_range(0, 63)));
            end
            else if (roll < 65)
            begin
                issue(CMD_REMOVE, pick_task(1'b1), prio, 6'($urandom_range(0, 63)));
            end
            else if (roll < 90)
            begin
                pick = $urandom_range(0, 2);
                if (pick == 0 || population == 0)
                begin
                    cur = 6'($urandom_range(0, 63));
                end
                else if (pick == 1)
                begin
                    cur = seen_next;
                end
                else
                begin
                    cur = pick_task(1'b1);
                end
                issue(CMD_SCHEDULE, 6'($urandom_range(0, 63)), prio, cur);
            end
            else
            begin
                // noise: double insert, remove of a free task, undefined command
                pick = $urandom_range(0, 2);
                if (pick == 0 && population > 0)
                begin
                    issue(CMD_INSERT, pick_task(1'b1), prio, 6'($urandom_range(0, 63)));
                end
                else if (pick == 1 && population < TASK_COUNT)
                begin
                    issue(CMD_REMOVE, pick_task(1'b0), prio, 6'($urandom_range(0, 63)));
                end
                else
                begin
                    issue(CMD_SPARE, 6'($urandom_range(0, 63)), prio,
                          6'($urandom_range(0, 63)));
                end
            end
        end
        cmd_ch.valid <= 1'b0;

        // let the last accept reach the checker, then drain
        no_stall = 1'b0;
        @(posedge clk);
        while (outstanding != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
        begin
            $display("No mismatches found");
        end
        else
        begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

>>> sim.f
rtl/prqs_pkg.sv
rtl/prqs_stream_if.sv
rtl/prqs_ram.sv
rtl/priority_ready_queue_scheduler_unit.sv
rtl/prqs_checker.sv
tb/sv/prqs_sched_checker.sv
tb/sv/priority_ready_queue_scheduler_unit_tb.sv
